// ===== hdl/swmd_pkg.sv =====
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and constants for the stack with middle-entry access.
// ----------------------------------------------------------------------------
`default_nettype none

package swmd_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

   // operation codes
   localparam logic [1:0] OP_PUSH       = 2'd0;
   localparam logic [1:0] OP_POP        = 2'd1;
   localparam logic [1:0] OP_READ_MID   = 2'd2;
   localparam logic [1:0] OP_DELETE_MID = 2'd3;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

   // read address select
   localparam logic [1:0] RD_TOP  = 2'd0;
   localparam logic [1:0] RD_MID  = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   // write address select
   localparam logic WR_PUSH = 1'b0;
   localparam logic WR_IDX  = 1'b1;

   // result value select
   localparam logic [1:0] RES_ECHO  = 2'd0;
   localparam logic [1:0] RES_EMPTY = 2'd1;
   localparam logic [1:0] RES_MEM   = 2'd2;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [31:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [1:0]         status;
      logic [COUNT_W-1:0] fill_count;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       mem_rd;
      logic [1:0] rd_sel;
      logic       mem_wr;
      logic       wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       idx_load;
      logic       idx_inc;
      logic       res_load;
      logic [1:0] res_sel;
      logic [1:0] res_status;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       is_empty;
      logic       is_full;
      logic       more_rdata;
      logic       more_wr;
      logic       out_busy;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/swmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// swmd_ctrl
// Sequencer: decodes the operation and steps the datapath through
// read, shift and result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module swmd_ctrl
   import swmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_RDATA    = 3'd2;
   localparam logic [2:0] S_SHIFT_RD = 3'd3;
   localparam logic [2:0] S_SHIFT_WR = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (sts.op == OP_PUSH) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ECHO;
               if (sts.is_full) begin
                  cmd.res_status = ST_FULL;
               end else begin
                  cmd.res_status = ST_OK;
                  cmd.mem_wr     = 1'b1;
                  cmd.wr_sel     = WR_PUSH;
                  cmd.cnt_inc    = 1'b1;
               end
               state_in = S_DONE;
            end else if (sts.is_empty) begin
               cmd.res_load   = 1'b1;
               cmd.res_sel    = RES_EMPTY;
               cmd.res_status = ST_EMPTY;
               state_in       = S_DONE;
            end else if (sts.op == OP_POP) begin
               cmd.mem_rd  = 1'b1;
               cmd.rd_sel  = RD_TOP;
               cmd.cnt_dec = 1'b1;
               state_in    = S_RDATA;
            end else begin
               cmd.mem_rd   = 1'b1;
               cmd.rd_sel   = RD_MID;
               cmd.idx_load = 1'b1;
               state_in     = S_RDATA;
            end
         end
         S_RDATA: begin
            cmd.res_load   = 1'b1;
            cmd.res_sel    = RES_MEM;
            cmd.res_status = ST_OK;
            if (sts.op == OP_DELETE_MID && sts.more_rdata) begin
               state_in = S_SHIFT_RD;
            end else begin
               cmd.cnt_dec = (sts.op == OP_DELETE_MID);
               state_in    = S_DONE;
            end
         end
         S_SHIFT_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_sel = RD_NEXT;
            state_in   = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.mem_wr  = 1'b1;
            cmd.wr_sel  = WR_IDX;
            cmd.idx_inc = 1'b1;
            if (sts.more_wr) begin
               state_in = S_SHIFT_RD;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // a request is only taken from idle
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load_req |-> state_ff == S_IDLE)
      else $error("request taken outside idle");

   // handoff of a result always returns to idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> state_ff == S_IDLE)
      else $error("result handoff did not return to idle");

   // count never moves both ways at once
   a_cnt_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("count incremented and decremented together");

endmodule

`default_nettype wire

// ===== hdl/swmd_dpath.sv =====
// ----------------------------------------------------------------------------
// swmd_dpath
// Entry memory, fill count, shift index, result staging and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swmd_dpath
   import swmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic signed [31:0] mem [STACK_DEPTH];
   logic signed [31:0] rd_data_ff;

   logic [1:0]         op_ff;
   logic signed [31:0] value_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [ADDR_W-1:0]  idx_ff;
   logic signed [31:0] res_value_ff;
   logic [1:0]         res_status_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_data_ff;

   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  wr_addr;
   logic signed [31:0] wr_data;
   logic [COUNT_W:0]   idx_ext;

   always_comb begin
      case (cmd.rd_sel)
         RD_TOP:  rd_addr = ADDR_W'(count_ff - COUNT_W'(1));
         RD_MID:  rd_addr = ADDR_W'(count_ff >> 1);
         RD_NEXT: rd_addr = idx_ff + ADDR_W'(1);
         default: rd_addr = idx_ff;
      endcase
      if (cmd.wr_sel == WR_PUSH) begin
         wr_addr = ADDR_W'(count_ff);
         wr_data = value_ff;
      end else begin
         wr_addr = idx_ff;
         wr_data = rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_wr) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.mem_rd) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - COUNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_data.operation;
         value_ff <= req_data.push_value;
      end
      if (cmd.idx_load) begin
         idx_ff <= ADDR_W'(count_ff >> 1);
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + ADDR_W'(1);
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         case (cmd.res_sel)
            RES_ECHO:  res_value_ff <= value_ff;
            RES_EMPTY: res_value_ff <= EMPTY_VALUE;
            default:   res_value_ff <= rd_data_ff;
         endcase
      end
      if (cmd.out_load) begin
         rsp_data_ff.result_value <= res_value_ff;
         rsp_data_ff.status       <= res_status_ff;
         rsp_data_ff.fill_count   <= count_ff;
      end
   end

   assign idx_ext = (COUNT_W + 1)'(idx_ff);

   always_comb begin
      sts.op         = op_ff;
      sts.is_empty   = (count_ff == '0);
      sts.is_full    = (count_ff == COUNT_W'(STACK_DEPTH));
      // entry above the middle still to move down
      sts.more_rdata = (idx_ext + (COUNT_W + 1)'(1)) < (COUNT_W + 1)'(count_ff);
      // after this write, one more entry to move
      sts.more_wr    = (idx_ext + (COUNT_W + 1)'(2)) < (COUNT_W + 1)'(count_ff);
      sts.out_busy   = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STACK_DEPTH))
      else $error("fill count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr && cmd.wr_sel == WR_PUSH) |-> count_ff < COUNT_W'(STACK_DEPTH))
      else $error("push write into a full stack");

   a_dec_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> count_ff != '0)
      else $error("count decremented at zero");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("output register overwritten before taken");

endmodule

`default_nettype wire

// ===== hdl/stack_with_middle_delete.sv =====
// ----------------------------------------------------------------------------
// stack_with_middle_delete
// Bounded stack of signed 32-bit values with read and delete of the
// middle entry (index count/2 from the bottom).
//
//   channel   direction   payload     beat taken when
//   req_      in          req_type    req_valid & req_ready
//   rsp_      out         rsp_type    rsp_valid & rsp_ready
//
// Push and every operation on an empty stack go from S_EXEC straight to
// result handoff; pop and read middle first read one entry. Delete middle
// then moves each entry above the middle down, one read and one write each.
// One item in flight; a new beat is taken while the previous result still
// waits in the output register, and the block holds at its end if that
// register is still full. Reset clears the sequencer state, the fill count
// and output valid; the entries themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_middle_delete
   import swmd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   cmd_type cmd;
   sts_type sts;

   swmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   swmd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
